// File: design/csd_pkg.sv
// Shared types and constants for the CSD digit encoder.
// Used by csd_ctrl, csd_dp, csd_digit_encoder and csd_checker; no dependencies.
package csd_pkg;

    // Configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 6;
    localparam int FP_W   = 5;
    localparam int NZ_W   = 6;

    localparam logic [CFG_AW-1:0] REG_COUNT_MODE      = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FRACTION_PLACES = 2'd1;
    localparam logic [CFG_AW-1:0] REG_NONZERO_LIMIT   = 2'd2;

    localparam logic [NZ_W-1:0] NZ_LIMIT_RESET = 6'd4;

    typedef enum logic [1:0] {
        SYM_ZERO  = 2'd0,
        SYM_PLUS  = 2'd1,
        SYM_MINUS = 2'd2,
        SYM_POINT = 2'd3
    } sym_t;

    typedef enum logic [1:0] {
        EMIT_ZERO_LAST = 2'd0,
        EMIT_LEAD_ZERO = 2'd1,
        EMIT_POINT     = 2'd2,
        EMIT_DIGIT     = 2'd3
    } emit_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_PREP  = 3'd1,
        ST_LEAD  = 3'd2,
        ST_ZERO  = 3'd3,
        ST_LZERO = 3'd4,
        ST_POINT = 3'd5,
        ST_DIGIT = 3'd6
    } state_t;

    typedef struct packed {
        logic      load;
        logic      prep;
        logic      lead;
        logic      emit;
        emit_sel_t sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_zero;
        logic small_mag;
        logic go_cur;
        logic go_next;
        logic pos_next_zero;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/csd_ctrl.sv
// Sequencing state machine of the CSD digit encoder.
// Depends on csd_pkg; drives commands into csd_dp and reads its status.
module csd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csd_pkg::dp_status_t status,
    output csd_pkg::ctrl_cmd_t  cmd
);
    import csd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = status.is_zero ? ST_ZERO : ST_LEAD;
            end
            ST_LEAD: begin
                state_next = status.small_mag ? ST_LZERO : ST_DIGIT;
            end
            ST_ZERO: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_LZERO: begin
                // leading zero sits at the radix position
                if (status.out_free) state_next = status.go_cur ? ST_POINT : ST_IDLE;
            end
            ST_POINT: begin
                if (status.out_free) state_next = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (status.out_free) begin
                    if (!status.go_next) state_next = ST_IDLE;
                    else if (status.pos_next_zero) state_next = ST_POINT;
                    else state_next = ST_DIGIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.prep = 1'b0;
        cmd.lead = 1'b0;
        cmd.emit = 1'b0;
        cmd.sel  = EMIT_DIGIT;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_PREP: cmd.prep = 1'b1;
            ST_LEAD: cmd.lead = 1'b1;
            ST_ZERO: begin
                cmd.emit = status.out_free;
                cmd.sel  = EMIT_ZERO_LAST;
            end
            ST_LZERO: begin
                cmd.emit = status.out_free;
                cmd.sel  = EMIT_LEAD_ZERO;
            end
            ST_POINT: begin
                cmd.emit = status.out_free;
                cmd.sel  = EMIT_POINT;
            end
            ST_DIGIT: begin
                cmd.emit = status.out_free;
                cmd.sel  = EMIT_DIGIT;
            end
            default: ;
        endcase
    end

endmodule

// File: design/csd_dp.sv
// Datapath of the CSD digit encoder: config registers, residual, digit position,
// nonzero budget and the output register. Depends on csd_pkg; driven by csd_ctrl.
module csd_dp #(
    parameter int INT_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [csd_pkg::CFG_AW-1:0]          cfg_addr,
    input  logic [csd_pkg::CFG_DW-1:0]          cfg_wdata,
    input  logic signed [INT_BITS+FRAC_BITS-1:0] s_value,
    input  csd_pkg::ctrl_cmd_t                  cmd,
    output csd_pkg::dp_status_t                 status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_symbol,
    output logic                                m_last
);
    import csd_pkg::*;

    localparam int W  = INT_BITS + FRAC_BITS;
    localparam int RW = W + 4;             // residual holds 3x value plus headroom
    localparam int MW = $clog2(RW);
    localparam int PW = MW + 1;            // signed digit position

    localparam logic signed [RW-1:0] THR3     = RW'(3) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] NEG_THR3 = -THR3;
    localparam logic signed [PW-1:0] FRAC_P   = PW'(FRAC_BITS);
    localparam logic signed [PW-1:0] NEG_FRAC = -FRAC_P;

    // configuration
    logic            count_mode_reg;
    logic [FP_W-1:0] fraction_places_reg;
    logic [NZ_W-1:0] nonzero_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_mode_reg      <= 1'b0;
            fraction_places_reg <= '0;
            nonzero_limit_reg   <= NZ_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_COUNT_MODE:      count_mode_reg      <= cfg_wdata[0];
                REG_FRACTION_PLACES: fraction_places_reg <= cfg_wdata[FP_W-1:0];
                REG_NONZERO_LIMIT:   nonzero_limit_reg   <= cfg_wdata[NZ_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [PW-1:0] places_c;
    logic signed [PW-1:0] neg_places;
    logic [NZ_W-1:0]      budget;

    assign places_c   = (PW'(fraction_places_reg) > FRAC_P) ? FRAC_P
                                                           : PW'(fraction_places_reg);
    assign neg_places = -places_c;
    assign budget     = (nonzero_limit_reg == '0) ? NZ_W'(1) : nonzero_limit_reg;

    // working state
    logic signed [RW-1:0] res_reg, res_next;
    logic [RW-1:0]        aux_reg;
    logic                 small_reg;
    logic signed [PW-1:0] pos_reg, pos_next;
    logic [NZ_W-1:0]      nzl_reg, nzl_next;

    logic signed [RW-1:0] v_ext;
    logic signed [RW-1:0] res_load;
    assign v_ext    = RW'(s_value);
    assign res_load = v_ext + (v_ext <<< 1);

    // leading position: msb of (3*|v| - 1) minus FRAC_BITS
    logic [MW-1:0]        msb;
    logic signed [PW-1:0] lead_pos;
    always_comb begin
        msb = '0;
        for (int i = 0; i < RW; i++) begin
            if (aux_reg[i]) msb = MW'(i);
        end
    end
    assign lead_pos = $signed(PW'(msb)) - FRAC_P;

    function automatic logic go_fn(input logic cm, input logic signed [PW-1:0] pos,
                                   input logic [NZ_W-1:0] nzl, input logic res_nz,
                                   input logic signed [PW-1:0] neg_pl,
                                   input logic signed [PW-1:0] neg_fr);
        logic g;
        if (cm) g = (pos > 0) || ((nzl != '0) && res_nz && (pos > neg_fr));
        else    g = pos > neg_pl;
        return g;
    endfunction

    // one digit step
    logic [PW-1:0]        e_w;
    logic signed [RW-1:0] thr, neg_thr, stp, neg_stp;
    logic                 dig_plus, dig_minus;
    logic [1:0]           dig_sym;
    logic                 res_next_nz;
    logic [NZ_W-1:0]      nzl_dec;

    assign e_w     = pos_reg + FRAC_P;
    assign thr     = RW'(1) << e_w;
    assign stp     = (RW'(3) << e_w) >>> 1;
    assign neg_thr = -thr;
    assign neg_stp = -stp;

    assign dig_plus  = res_reg > thr;
    assign dig_minus = !dig_plus && (res_reg < neg_thr);

    always_comb begin
        nzl_dec = nzl_reg;
        if ((dig_plus || dig_minus) && nzl_reg != '0) nzl_dec = nzl_reg - NZ_W'(1);
        if (dig_plus) begin
            dig_sym     = SYM_PLUS;
            res_next    = res_reg - stp;
            res_next_nz = res_reg != stp;
        end else if (dig_minus) begin
            dig_sym     = SYM_MINUS;
            res_next    = res_reg + stp;
            res_next_nz = res_reg != neg_stp;
        end else begin
            dig_sym     = SYM_ZERO;
            res_next    = res_reg;
            res_next_nz = res_reg != '0;
        end
        // budget spent in count mode: residual is dropped
        if (count_mode_reg && nzl_dec == '0) res_next = '0;
    end

    assign pos_next = pos_reg - PW'(1);
    assign nzl_next = nzl_dec;

    always_ff @(posedge aclk) begin
        if (cmd.load) res_reg <= res_load;
        if (cmd.prep) begin
            aux_reg   <= res_reg[RW-1] ? ~res_reg : res_reg - RW'(1);
            small_reg <= (res_reg > NEG_THR3) && (res_reg < THR3);
        end
        if (cmd.lead) begin
            pos_reg <= small_reg ? '0 : lead_pos;
            nzl_reg <= budget;
        end
        if (cmd.emit && cmd.sel == EMIT_DIGIT) begin
            res_reg <= res_next;
            pos_reg <= pos_next;
            nzl_reg <= nzl_next;
        end
    end

    // output register
    logic       m_valid_reg;
    logic [1:0] sym_reg, sym_next;
    logic       last_reg, last_next;

    always_comb begin
        case (cmd.sel)
            EMIT_ZERO_LAST: begin
                sym_next  = SYM_ZERO;
                last_next = 1'b1;
            end
            EMIT_LEAD_ZERO: begin
                sym_next  = SYM_ZERO;
                last_next = !status.go_cur;
            end
            EMIT_POINT: begin
                sym_next  = SYM_POINT;
                last_next = 1'b0;
            end
            default: begin
                sym_next  = dig_sym;
                last_next = !status.go_next;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            sym_reg  <= sym_next;
            last_reg <= last_next;
        end
    end

    assign status.is_zero       = res_reg == '0;
    assign status.small_mag     = small_reg;
    assign status.go_cur        = go_fn(count_mode_reg, pos_reg, nzl_reg, res_reg != '0,
                                        neg_places, NEG_FRAC);
    assign status.go_next       = go_fn(count_mode_reg, pos_next, nzl_next, res_next_nz,
                                        neg_places, NEG_FRAC);
    assign status.pos_next_zero = pos_next == '0;
    assign status.out_free      = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_symbol = sym_reg;
    assign m_last   = last_reg;

endmodule

// File: design/csd_digit_encoder.sv
// CSD digit encoder: setup steps after an item is accepted (load 3x value,
// magnitude and small-value check, leading position unless the value is zero),
// then one symbol per cycle into the output register while the output is free.
// The next item is accepted once the last symbol is in the output register.
// Synchronous active-low reset clears the controller, output valid and config.
// Top level; instantiates csd_ctrl and csd_dp, uses csd_pkg.
module csd_digit_encoder #(
    parameter int INT_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [csd_pkg::CFG_AW-1:0]           cfg_addr,
    input  logic [csd_pkg::CFG_DW-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [INT_BITS+FRAC_BITS-1:0] s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_symbol,
    output logic                                 m_last
);
    import csd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    csd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    csd_dp #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_value   (s_value),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_symbol  (m_symbol),
        .m_last    (m_last)
    );

endmodule

// File: design/csd_checker.sv
// Port-level checks for csd_digit_encoder, attached by the bind below.
// Depends on csd_pkg for the symbol codes.
module csd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_symbol,
    input logic       m_last
);
    import csd_pkg::*;

    // a stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol) && $stable(m_last))
        else $error("output item changed while stalled");

    // one item at a time: busy right after accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous item in progress");

    // a radix point is always followed by a digit
    a_point_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_symbol == SYM_POINT) |-> !m_last)
        else $error("radix point flagged as last symbol");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind csd_digit_encoder csd_checker u_csd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_symbol (m_symbol),
    .m_last   (m_last)
);

// File: dv/csd_digit_encoder_tb.sv
// Self-checking testbench for csd_digit_encoder: directed table, then random values.
// Each symbol is checked against typed text or an in-bench CSD recoder; needs csd_pkg and the design.
module csd_digit_encoder_tb;
    import csd_pkg::*;

    localparam int INT_BITS    = 16;
    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 45;
    localparam int DIR_N       = 25;
    localparam int PRINT_CAP   = 50;

    typedef struct packed {
        logic            count_mode;
        logic [FP_W-1:0] fraction_places;
        logic [NZ_W-1:0] nonzero_limit;
    } enc_cfg_t;

    typedef struct {
        sym_t sym;
        logic last;
        int   item;
    } symbol_entry_t;

    // typed: expected symbols as text ("+-0."), empty means use the recoder
    typedef struct {
        enc_cfg_t    cfg;
        logic [31:0] value;
        string       typed;
    } dir_row_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [CFG_AW-1:0]                    cfg_addr = '0;
    logic [CFG_DW-1:0]                    cfg_wdata = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic signed [INT_BITS+FRAC_BITS-1:0] s_value = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [1:0]                           m_symbol;
    logic                                 m_last;

    symbol_entry_t expected_symbols[$];
    enc_cfg_t      cur_cfg = '{count_mode: 1'b0, fraction_places: '0,
                               nonzero_limit: NZ_LIMIT_RESET};
    int            error_count = 0;
    int            values_sent = 0;
    int            symbols_seen = 0;
    int            settings_used = 0;
    int            cycle_count = 0;
    bit            tx_idle = 1'b1;
    bit            rx_idle = 1'b1;
    bit            hold_armed = 1'b0;
    bit            hold_done = 1'b0;
    int            rx_gap = 0;

    dir_row_t directed_rows [DIR_N] = '{
        // reset settings: place mode, no fraction places
        '{'{1'b0, 5'd0,  6'd4},  32'h0000_0000, "0"},
        '{'{1'b0, 5'd0,  6'd4},  32'h0000_8000, "0"},
        '{'{1'b0, 5'd0,  6'd4},  32'h0000_0001, "0"},
        '{'{1'b0, 5'd0,  6'd4},  32'h0001_0000, "+"},
        '{'{1'b0, 5'd0,  6'd4},  32'hFFFF_0000, "-"},
        '{'{1'b0, 5'd0,  6'd4},  32'h0002_0000, "+0"},
        '{'{1'b0, 5'd0,  6'd4},  32'h7FFF_FFFF, ""},
        '{'{1'b0, 5'd0,  6'd4},  32'h8000_0000, ""},
        // all fraction places
        '{'{1'b0, 5'd16, 6'd4},  32'h0000_0001, ""},
        '{'{1'b0, 5'd16, 6'd4},  32'h7FFF_FFFF, ""},
        '{'{1'b0, 5'd16, 6'd4},  32'h8000_0000, ""},
        '{'{1'b0, 5'd16, 6'd4},  32'hFFFF_FFFF, ""},
        '{'{1'b0, 5'd16, 6'd4},  32'h0000_5555, ""},
        '{'{1'b0, 5'd16, 6'd4},  32'h1234_5678, ""},
        // fraction places beyond the fraction width are clamped
        '{'{1'b0, 5'd31, 6'd4},  32'h0000_0001, ""},
        '{'{1'b0, 5'd31, 6'd4},  32'hAAAA_AAAA, ""},
        // count mode, single nonzero digit
        '{'{1'b1, 5'd0,  6'd1},  32'h7FFF_FFFF, ""},
        '{'{1'b1, 5'd0,  6'd1},  32'h0000_0001, ""},
        '{'{1'b1, 5'd0,  6'd1},  32'h0001_8000, ""},
        // count mode, wide budget: stops on zero residual or fraction width
        '{'{1'b1, 5'd0,  6'd32}, 32'h5555_5555, ""},
        '{'{1'b1, 5'd0,  6'd32}, 32'hFFFF_FFFF, ""},
        '{'{1'b1, 5'd0,  6'd32}, 32'h0001_0000, ""},
        '{'{1'b1, 5'd0,  6'd32}, 32'h0000_AAAA, ""},
        // zero budget acts as one
        '{'{1'b1, 5'd0,  6'd0},  32'h0003_0000, ""},
        '{'{1'b1, 5'd5,  6'd0},  32'h0000_0000, "0"}
    };

    csd_digit_encoder #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_symbol  (m_symbol),
        .m_last    (m_last)
    );

    always #5 aclk = ~aclk;

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP) $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic void queue_symbols(input sym_t syms[$], input int item);
        foreach (syms[i])
            expected_symbols.push_back('{sym: syms[i], last: (i == syms.size() - 1),
                                         item: item});
    endfunction

    // CSD recoding with residual kept as 3x the value in LSB units
    function automatic void recode_value(input logic signed [31:0] value, input int item);
        longint v, resid, mag, thr, step;
        int     n, k, e, places, left;
        bit     go;
        sym_t   syms[$];
        v = longint'(value);
        if (v == 0) begin
            syms.push_back(SYM_ZERO);
        end else begin
            resid = 3 * v;
            mag = (v < 0) ? -v : v;
            if (mag < (64'sd1 <<< FRAC_BITS)) begin
                n = 0;
                syms.push_back(SYM_ZERO);
            end else begin
                k = 0;
                while (k < 40 && (64'sd1 <<< k) < 3 * mag) k++;
                n = k - FRAC_BITS - 1;
            end
            places = (int'(cur_cfg.fraction_places) > FRAC_BITS) ? FRAC_BITS
                                                                : int'(cur_cfg.fraction_places);
            left = (cur_cfg.nonzero_limit == 0) ? 1 : int'(cur_cfg.nonzero_limit);
            go = 1'b1;
            while (go) begin
                if (!cur_cfg.count_mode) go = (n > -places);
                else go = (n > 0) || (left > 0 && resid != 0 && n > -FRAC_BITS);
                if (go) begin
                    if (n == 0) syms.push_back(SYM_POINT);
                    e = n + FRAC_BITS;
                    n--;
                    thr = 64'sd1 <<< e;
                    step = 3 * (64'sd1 <<< (e - 1));
                    if (resid > thr) begin
                        syms.push_back(SYM_PLUS);
                        resid -= step;
                        if (left > 0) left--;
                    end else if (resid < -thr) begin
                        syms.push_back(SYM_MINUS);
                        resid += step;
                        if (left > 0) left--;
                    end else begin
                        syms.push_back(SYM_ZERO);
                    end
                    if (cur_cfg.count_mode && left == 0) resid = 0;
                end
            end
        end
        queue_symbols(syms, item);
    endfunction

    function automatic void queue_typed(input string typed, input int item);
        sym_t syms[$];
        for (int i = 0; i < typed.len(); i++) begin
            case (typed[i])
                "+":     syms.push_back(SYM_PLUS);
                "-":     syms.push_back(SYM_MINUS);
                ".":     syms.push_back(SYM_POINT);
                default: syms.push_back(SYM_ZERO);
            endcase
        end
        queue_symbols(syms, item);
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input enc_cfg_t next);
        if (next != cur_cfg) begin
            wait_idle();
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_COUNT_MODE;
            cfg_wdata <= CFG_DW'(next.count_mode);
            @(posedge aclk);
            cfg_addr  <= REG_FRACTION_PLACES;
            cfg_wdata <= CFG_DW'(next.fraction_places);
            @(posedge aclk);
            cfg_addr  <= REG_NONZERO_LIMIT;
            cfg_wdata <= CFG_DW'(next.nonzero_limit);
            @(posedge aclk);
            cfg_we    <= 1'b0;
            cur_cfg = next;
            settings_used++;
        end
    endtask

    // valid stays high across back-to-back items; dropped only for a gap or a drain
    task automatic offer_value(input logic [31:0] value, input string typed);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        if (typed.len() == 0) recode_value(value, values_sent);
        else queue_typed(typed, values_sent);
        values_sent++;
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] r;
        case ($urandom_range(0, 9))
            0: r = '0;
            1: r = $urandom_range(1, 65535);
            2: r = -$urandom_range(1, 65535);
            3: begin
                r = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
                if ($urandom_range(0, 1)) r = -r;
            end
            4: begin
                case ($urandom_range(0, 5))
                    0:       r = 32'h7FFF_FFFF;
                    1:       r = 32'h8000_0000;
                    2:       r = 32'hFFFF_FFFF;
                    3:       r = 32'h0000_0001;
                    4:       r = 32'h0001_0000;
                    default: r = 32'hFFFF_0000;
                endcase
            end
            default: r = $urandom();
        endcase
        return r;
    endfunction

    function automatic enc_cfg_t phase_config(input int phase);
        enc_cfg_t c;
        case (phase)
            0:       c = '{1'b0, 5'd16, 6'd4};
            1:       c = '{1'b1, 5'd0,  6'd1};
            2:       c = '{1'b1, 5'd16, 6'd32};
            3:       c = '{1'b0, 5'd0,  6'd4};
            default: begin
                c.count_mode = 1'($urandom_range(0, 1));
                c.fraction_places = ($urandom_range(0, 7) == 0) ?
                                    FP_W'($urandom_range(17, 31)) :
                                    FP_W'($urandom_range(0, 16));
                c.nonzero_limit = NZ_W'($urandom_range(1, 32));
            end
        endcase
        return c;
    endfunction

    // result side: ready drops for a random gap after items while rx_idle, plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) rx_gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (hold_armed && !hold_done) begin
                rx_gap = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : symbol_monitor
        symbol_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            symbols_seen++;
            if (expected_symbols.size() == 0) begin
                report_error($sformatf("unexpected symbol %0d last %0d", m_symbol, m_last));
            end else begin
                want = expected_symbols.pop_front();
                if (m_symbol !== want.sym)
                    report_error($sformatf("item %0d: symbol %0d, expected %0d",
                                           want.item, m_symbol, want.sym));
                if (m_last !== want.last)
                    report_error($sformatf("item %0d: last %0d, expected %0d",
                                           want.item, m_last, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d symbols outstanding",
                     cycle_count, expected_symbols.size());
            $display("csd_digit_encoder_tb failed");
            $finish;
        end
    end

    initial begin
        int drain;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            set_config(directed_rows[i].cfg);
            offer_value(directed_rows[i].value, directed_rows[i].typed);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_config(p));
            // phase 1 runs with no gaps on either side
            tx_idle <= (p != 1);
            rx_idle <= (p != 1);
            if (p == 2) hold_armed <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                offer_value(random_value(), "");
                // sender drains mid-phase once
                if (p == 3 && i == PHASE_ITEMS / 2) wait_idle();
            end
        end

        s_valid <= 1'b0;
        drain = 0;
        while (expected_symbols.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (40) @(posedge aclk);
        if (expected_symbols.size() != 0)
            report_error($sformatf("%0d symbols never arrived", expected_symbols.size()));

        $display("covered %0d values and %0d symbols under %0d register settings,",
                 values_sent, symbols_seen, settings_used);
        $display("spanning place, count, clamped-place and zero-budget cases");
        if (error_count == 0) begin
            $display("csd_digit_encoder_tb passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("csd_digit_encoder_tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/csd_pkg.sv
design/csd_ctrl.sv
design/csd_dp.sv
design/csd_digit_encoder.sv
design/csd_checker.sv
dv/csd_digit_encoder_tb.sv
